// ----- rtl/core/dqpsk_pkg.sv -----
// shared types, constants and table functions for the dqpsk pulse shaping modulator
// no dependencies; used by the interfaces and every module of the block

package dqpsk_pkg;

    // default sizing of the pulse span and interpolation
    localparam int DEF_MAX_INTERP   = 8;
    localparam int DEF_SPAN_SYMBOLS = 10;

    // fixed field widths
    localparam int COEF_IDX_W = 7;
    localparam int SAMPLE_W   = 16;
    localparam int INTERP_W   = 4;
    localparam int DIBIT_W    = 2;
    localparam int PHASE_W    = 2;

    // command codes of an input beat
    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SYMBOL = 1'b1
    } cmd_code_t;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCUM,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic coef_load;
        logic sym_start;
        logic acc_en;
        logic emit_en;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic acc_done;
        logic emit_done;
    } dp_sts_t;

    // differential phase step for a dibit (gray coded)
    localparam logic [PHASE_W-1:0] PHASE_STEP [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

    // in-phase sign: negative for phases 0 and 1
    function automatic logic neg_i(input logic [PHASE_W-1:0] phase);
        return ~phase[1];
    endfunction

    // quadrature sign: negative for phases 0 and 3
    function automatic logic neg_q(input logic [PHASE_W-1:0] phase);
        return (phase == 2'd0) || (phase == 2'd3);
    endfunction

endpackage

// ----- rtl/core/dqpsk_if.sv -----
// valid/ready channel interfaces: symbol/load beats, output samples, config writes
// depends on dqpsk_pkg for field widths

interface dqpsk_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic [dqpsk_pkg::COEF_IDX_W-1:0]       coef_index;
    logic signed [dqpsk_pkg::SAMPLE_W-1:0]  coef_value;
    logic [dqpsk_pkg::DIBIT_W-1:0]          dibit;
    logic                                   block_last;

    modport source (output valid, command, coef_index, coef_value, dibit, block_last,
                    input ready);
    modport sink (input valid, command, coef_index, coef_value, dibit, block_last,
                  output ready);
endinterface

interface dqpsk_smp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dqpsk_pkg::SAMPLE_W-1:0]  sample_i;
    logic signed [dqpsk_pkg::SAMPLE_W-1:0]  sample_q;
    logic                                   last_of_symbol;
    logic                                   block_end;

    modport source (output valid, sample_i, sample_q, last_of_symbol, block_end,
                    input ready);
    modport sink (input valid, sample_i, sample_q, last_of_symbol, block_end,
                  output ready);
endinterface

interface dqpsk_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dqpsk_pkg::INTERP_W-1:0]     interpolation;

    modport source (output valid, interpolation, input ready);
    modport sink (input valid, interpolation, output ready);
endinterface

// ----- rtl/core/dqpsk_ctrl.sv -----
// controller state machine: clearing pass, coefficient load, accumulate and emit phases
// depends on dqpsk_pkg for state, command and status types

module dqpsk_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    input  logic                cfg_fire,
    output logic                in_ready,
    output dqpsk_pkg::dp_cmd_t  dp_cmd,
    input  dqpsk_pkg::dp_sts_t  dp_sts
);

    dqpsk_pkg::state_t state_reg;
    dqpsk_pkg::state_t state_next;

    // state register, a clearing pass follows reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqpsk_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        dp_cmd     = '0;
        case (state_reg)
            dqpsk_pkg::ST_CLEAR:
            begin
                dp_cmd.clear_en = 1'b1;
                if (dp_sts.clear_done)
                begin
                    state_next = dqpsk_pkg::ST_IDLE;
                end
            end
            dqpsk_pkg::ST_IDLE:
            begin
                // an interpolation write in the same cycle holds off the input beat
                in_ready = !cfg_fire;
                if (in_valid && !cfg_fire)
                begin
                    if (in_command == dqpsk_pkg::CMD_SYMBOL)
                    begin
                        dp_cmd.sym_start = 1'b1;
                        state_next       = dqpsk_pkg::ST_ACCUM;
                    end
                    else
                    begin
                        dp_cmd.coef_load = 1'b1;
                    end
                end
            end
            dqpsk_pkg::ST_ACCUM:
            begin
                dp_cmd.acc_en = 1'b1;
                if (dp_sts.acc_done)
                begin
                    state_next = dqpsk_pkg::ST_DRAIN;
                end
            end
            dqpsk_pkg::ST_DRAIN:
            begin
                // last window write-back lands here
                state_next = dqpsk_pkg::ST_EMIT;
            end
            dqpsk_pkg::ST_EMIT:
            begin
                dp_cmd.emit_en = 1'b1;
                if (dp_sts.emit_done)
                begin
                    state_next = dqpsk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dqpsk_pkg::ST_CLEAR;
            end
        endcase
        // an interpolation write restarts the clearing pass
        if (cfg_fire)
        begin
            state_next = dqpsk_pkg::ST_CLEAR;
        end
    end

endmodule

// ----- rtl/core/dqpsk_dpath.sv -----
// datapath: coefficient store, i/q overlap-add windows, phase, counters, output register
// depends on dqpsk_pkg; driven by dqpsk_ctrl through command and status structs

module dqpsk_dpath #(
    parameter int MAX_INTERP   = dqpsk_pkg::DEF_MAX_INTERP,
    parameter int SPAN_SYMBOLS = dqpsk_pkg::DEF_SPAN_SYMBOLS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dqpsk_pkg::dp_cmd_t                      dp_cmd,
    output dqpsk_pkg::dp_sts_t                      dp_sts,
    input  logic                                    cfg_fire,
    input  logic [dqpsk_pkg::INTERP_W-1:0]          cfg_interp,
    input  logic [dqpsk_pkg::COEF_IDX_W-1:0]        coef_index,
    input  logic signed [dqpsk_pkg::SAMPLE_W-1:0]   coef_value,
    input  logic [dqpsk_pkg::DIBIT_W-1:0]           dibit,
    input  logic                                    block_last,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [dqpsk_pkg::SAMPLE_W-1:0]   sample_i,
    output logic signed [dqpsk_pkg::SAMPLE_W-1:0]   sample_q,
    output logic                                    last_of_symbol,
    output logic                                    block_end
);

    localparam int TAP_DEPTH = SPAN_SYMBOLS * MAX_INTERP + 1;
    localparam int AW        = $clog2(TAP_DEPTH);
    localparam int IW        = $clog2(MAX_INTERP + 1);
    localparam int SW        = dqpsk_pkg::SAMPLE_W;
    localparam int PW        = dqpsk_pkg::PHASE_W;

    // memories
    logic [SW-1:0] coef_mem  [TAP_DEPTH];
    logic [SW-1:0] win_i_mem [TAP_DEPTH];
    logic [SW-1:0] win_q_mem [TAP_DEPTH];

    // control registers
    logic [IW-1:0] interp_reg;
    logic [AW-1:0] last_slot_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [PW-1:0] phase_reg;
    logic          blk_last_reg;
    logic [AW-1:0] tap_reg;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] clr_reg;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    logic [IW-1:0] issue_cnt_reg;
    logic          rd_pending_reg;
    logic          rd_last_reg;
    logic          out_valid_reg;

    // read data and output payload
    logic [SW-1:0] coef_rd_reg;
    logic [SW-1:0] win_i_rd_reg;
    logic [SW-1:0] win_q_rd_reg;
    logic [SW-1:0] out_i_reg;
    logic [SW-1:0] out_q_reg;
    logic          out_last_reg;
    logic          out_blk_reg;

    // combinational helpers
    logic [7:0]    cfg_ext;
    logic [7:0]    act_interp;
    logic [AW-1:0] pos_start;
    logic [AW-1:0] slot_inc;
    logic [AW-1:0] pos_inc;
    logic          coef_in_range;
    logic          move;
    logic          emit_issue;
    logic          win_re;
    logic [AW-1:0] win_ra;
    logic          win_we;
    logic [AW-1:0] win_wa;
    logic [SW-1:0] win_wd_i;
    logic [SW-1:0] win_wd_q;
    logic [SW-1:0] coef_i;
    logic [SW-1:0] coef_q;

    // interpolation saturated to 1..MAX_INTERP
    always_comb
    begin
        cfg_ext = 8'(cfg_interp);
        if (cfg_ext == 8'd0)
        begin
            act_interp = 8'd1;
        end
        else if (cfg_ext > 8'(MAX_INTERP))
        begin
            act_interp = 8'(MAX_INTERP);
        end
        else
        begin
            act_interp = cfg_ext;
        end
    end

    // window position and slot stepping with wrap at the window length
    assign pos_start     = (pos_reg > last_slot_reg) ? '0 : pos_reg;
    assign slot_inc      = (slot_reg == last_slot_reg) ? '0 : AW'(slot_reg + AW'(1));
    assign pos_inc       = (pos_reg == last_slot_reg) ? '0 : AW'(pos_reg + AW'(1));
    assign coef_in_range = 32'(coef_index) < 32'(TAP_DEPTH);

    // output handshake: move read data into the output register, issue next read
    assign move       = rd_pending_reg && (!out_valid_reg || out_ready);
    assign emit_issue = dp_cmd.emit_en && (issue_cnt_reg != interp_reg)
                        && (!rd_pending_reg || move);

    // status to controller
    assign dp_sts.clear_done = dp_cmd.clear_en && (clr_reg == AW'(TAP_DEPTH - 1));
    assign dp_sts.acc_done   = dp_cmd.acc_en && (tap_reg == last_slot_reg);
    assign dp_sts.emit_done  = dp_cmd.emit_en && (issue_cnt_reg == interp_reg)
                               && !rd_pending_reg;

    // signed pulse per carrier phase, negation wraps in 16 bits
    assign coef_i = dqpsk_pkg::neg_i(phase_reg) ? SW'(-coef_rd_reg) : coef_rd_reg;
    assign coef_q = dqpsk_pkg::neg_q(phase_reg) ? SW'(-coef_rd_reg) : coef_rd_reg;

    // window port selection
    always_comb
    begin
        win_re   = dp_cmd.acc_en || emit_issue;
        win_ra   = dp_cmd.acc_en ? slot_reg : pos_reg;
        win_we   = 1'b0;
        win_wa   = pos_reg;
        win_wd_i = '0;
        win_wd_q = '0;
        if (dp_cmd.clear_en)
        begin
            win_we = 1'b1;
            win_wa = clr_reg;
        end
        else if (wb_valid_reg)
        begin
            win_we   = 1'b1;
            win_wa   = wb_addr_reg;
            win_wd_i = SW'(win_i_rd_reg + coef_i);
            win_wd_q = SW'(win_q_rd_reg + coef_q);
        end
        else if (emit_issue)
        begin
            win_we = 1'b1;
        end
    end

    // next window position
    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_fire)
        begin
            pos_next = '0;
        end
        else if (dp_cmd.sym_start)
        begin
            pos_next = pos_start;
        end
        else if (emit_issue)
        begin
            pos_next = pos_inc;
        end
    end

    // coefficient store
    always_ff @(posedge clk)
    begin
        if (dp_cmd.coef_load && coef_in_range)
        begin
            coef_mem[AW'(coef_index)] <= coef_value;
        end
        if (dp_cmd.acc_en)
        begin
            coef_rd_reg <= coef_mem[tap_reg];
        end
    end

    // i/q windows, read-first
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_i_mem[win_wa] <= win_wd_i;
            win_q_mem[win_wa] <= win_wd_q;
        end
        if (win_re)
        begin
            win_i_rd_reg <= win_i_mem[win_ra];
            win_q_rd_reg <= win_q_mem[win_ra];
        end
    end

    // configuration, phase and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg     <= IW'(1);
            last_slot_reg  <= AW'(SPAN_SYMBOLS);
            pos_reg        <= '0;
            phase_reg      <= '0;
            blk_last_reg   <= 1'b0;
            tap_reg        <= '0;
            slot_reg       <= '0;
            clr_reg        <= '0;
            wb_valid_reg   <= 1'b0;
            wb_addr_reg    <= '0;
            issue_cnt_reg  <= '0;
            rd_pending_reg <= 1'b0;
            rd_last_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            wb_valid_reg <= dp_cmd.acc_en;

            // interpolation write
            if (cfg_fire)
            begin
                interp_reg    <= IW'(act_interp);
                last_slot_reg <= AW'(SPAN_SYMBOLS * int'(act_interp));
            end

            // clearing pass address
            if (cfg_fire)
            begin
                clr_reg <= '0;
            end
            else if (dp_cmd.clear_en)
            begin
                clr_reg <= AW'(clr_reg + AW'(1));
            end

            // symbol start: advance phase, set up the tap sweep
            if (dp_cmd.sym_start)
            begin
                phase_reg     <= PW'(phase_reg + dqpsk_pkg::PHASE_STEP[dibit]);
                blk_last_reg  <= block_last;
                tap_reg       <= '0;
                slot_reg      <= pos_start;
                issue_cnt_reg <= '0;
            end

            // tap sweep
            if (dp_cmd.acc_en)
            begin
                tap_reg     <= AW'(tap_reg + AW'(1));
                slot_reg    <= slot_inc;
                wb_addr_reg <= slot_reg;
            end

            // sample reads
            if (emit_issue)
            begin
                issue_cnt_reg <= IW'(issue_cnt_reg + IW'(1));
                rd_last_reg   <= (issue_cnt_reg == IW'(interp_reg - IW'(1)));
            end

            if (emit_issue)
            begin
                rd_pending_reg <= 1'b1;
            end
            else if (move)
            begin
                rd_pending_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_i_reg    <= win_i_rd_reg;
            out_q_reg    <= win_q_rd_reg;
            out_last_reg <= rd_last_reg;
            out_blk_reg  <= rd_last_reg && blk_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_i       = out_i_reg;
    assign sample_q       = out_q_reg;
    assign last_of_symbol = out_last_reg;
    assign block_end      = out_blk_reg;

endmodule

// ----- rtl/core/dqpsk_pulse_shaping_modulator.sv -----
// differential qpsk modulator with overlap-add pulse shaping, ntaps = SPAN_SYMBOLS*interp+1
// a symbol beat runs a window read-modify-write for each of the ntaps taps, passes the drain
// state, then gives one sample per cycle while smp.ready does not hold it off; the next
// symbol or load beat is taken only once the last sample of the symbol is in the output register
// after reset and after each interpolation write a clearing pass zeroes all
// SPAN_SYMBOLS*MAX_INTERP+1 window slots; symbol/load beats are held off until it ends
// depends on dqpsk_pkg, dqpsk_if, dqpsk_ctrl and dqpsk_dpath

module dqpsk_pulse_shaping_modulator #(
    parameter int MAX_INTERP   = dqpsk_pkg::DEF_MAX_INTERP,
    parameter int SPAN_SYMBOLS = dqpsk_pkg::DEF_SPAN_SYMBOLS
) (
    input  logic        clk,
    input  logic        rst_n,
    dqpsk_cmd_if.sink   cmd,
    dqpsk_smp_if.source smp,
    dqpsk_cfg_if.sink   cfg
);

    dqpsk_pkg::dp_cmd_t dp_cmd;
    dqpsk_pkg::dp_sts_t dp_sts;
    logic               cfg_fire;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    // controller
    dqpsk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_command (cmd.command),
        .cfg_fire   (cfg_fire),
        .in_ready   (cmd.ready),
        .dp_cmd     (dp_cmd),
        .dp_sts     (dp_sts)
    );

    // datapath
    dqpsk_dpath #(
        .MAX_INTERP   (MAX_INTERP),
        .SPAN_SYMBOLS (SPAN_SYMBOLS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .cfg_fire       (cfg_fire),
        .cfg_interp     (cfg.interpolation),
        .coef_index     (cmd.coef_index),
        .coef_value     (cmd.coef_value),
        .dibit          (cmd.dibit),
        .block_last     (cmd.block_last),
        .out_valid      (smp.valid),
        .out_ready      (smp.ready),
        .sample_i       (smp.sample_i),
        .sample_q       (smp.sample_q),
        .last_of_symbol (smp.last_of_symbol),
        .block_end      (smp.block_end)
    );

endmodule
